// ===== hdl/swia_pkg.sv =====
package swia_pkg;

  localparam int DataWidth = 64;
  localparam int OpWidth = (DataWidth > 64) ? 64 : DataWidth;
  localparam int CntWidth = $clog2(OpWidth);
  localparam int StepWidth = $clog2(OpWidth + 1);
  localparam int QueueDepth = 2;
  localparam int HalfWidth = (OpWidth + 1) / 2;
  localparam int FullWidth = 2 * HalfWidth;

  typedef enum logic [4:0] {
    OP_POW = 5'd0, OP_MUL = 5'd1, OP_DIV = 5'd2, OP_MOD = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_SHL = 5'd6, OP_SAR = 5'd7,
    OP_LT = 5'd8, OP_LE = 5'd9, OP_GT = 5'd10, OP_GE = 5'd11,
    OP_EQ = 5'd12, OP_NE = 5'd13, OP_AND = 5'd14, OP_XOR = 5'd15,
    OP_OR = 5'd16, OP_LAND = 5'd17, OP_LOR = 5'd18
  } op_t;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV_ZERO = 2'd1;
  localparam logic [1:0] FAULT_NEG_EXP = 2'd2;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0, KIND_MUL = 2'd1, KIND_DIV = 2'd2, KIND_POW = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_POW_MUL, ST_POW_SQR, ST_FIX, ST_DONE
  } state_t;

  typedef struct packed {
    logic [4:0] req_type;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;
    logic suppress_faults;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0] fault_code;
  } out_word_t;

  typedef struct packed {
    kind_t kind;
    logic is_mod;
    logic neg_res;
    logic [OpWidth-1:0] a;
    logic [OpWidth-1:0] b;
    logic [OpWidth-1:0] direct;
    logic [1:0] fault;
  } task_t;

  function automatic logic [OpWidth-1:0] trim(input logic [63:0] v);
    return v[OpWidth-1:0];
  endfunction

  function automatic logic [63:0] widen(input logic [OpWidth-1:0] v);
    return 64'($signed(v));
  endfunction

endpackage

// ===== hdl/swia_front.sv =====
module swia_front import swia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  output logic     q_valid,
  input  logic     q_pop,
  output task_t    q_head
);

  task_t q_mem_r [QueueDepth];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  task_t t;
  logic [OpWidth-1:0] a, b, minv, ma, mb, onev;
  logic [CntWidth-1:0] cnt;
  logic push;

  assign in_stall = (q_cnt_r == 2'(QueueDepth));
  assign push = in_valid && !in_stall;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_head = q_mem_r[q_rp_r];

  always_comb begin
    a = trim(in_word.left_operand);
    b = trim(in_word.right_operand);
    minv = {1'b1, {(OpWidth-1){1'b0}}};
    onev = {{(OpWidth-1){1'b0}}, 1'b1};
    ma = a[OpWidth-1] ? -a : a;
    mb = b[OpWidth-1] ? -b : b;
    cnt = b[CntWidth-1:0];
    t = '0;
    t.kind = KIND_DIRECT;
    t.a = a;
    t.b = b;
    case (in_word.req_type)
      OP_POW: begin
        if (b[OpWidth-1]) begin
          t.fault = FAULT_NEG_EXP;
        end else begin
          t.kind = KIND_POW;
        end
      end
      OP_MUL: t.kind = KIND_MUL;
      OP_DIV, OP_MOD: begin
        t.is_mod = (in_word.req_type == OP_MOD);
        if (b == '0) begin
          t.fault = FAULT_DIV_ZERO;
        end else if (a == minv && b == '1) begin
          t.direct = t.is_mod ? '0 : minv;
        end else begin
          t.kind = KIND_DIV;
          t.a = ma;
          t.b = mb;
          t.neg_res = t.is_mod ? a[OpWidth-1] : (a[OpWidth-1] ^ b[OpWidth-1]);
        end
      end
      OP_ADD: t.direct = a + b;
      OP_SUB: t.direct = a - b;
      OP_SHL: t.direct = a << cnt;
      OP_SAR: t.direct = OpWidth'($signed(a) >>> cnt);
      OP_LT: t.direct = ($signed(a) < $signed(b)) ? onev : '0;
      OP_LE: t.direct = ($signed(a) <= $signed(b)) ? onev : '0;
      OP_GT: t.direct = ($signed(a) > $signed(b)) ? onev : '0;
      OP_GE: t.direct = ($signed(a) >= $signed(b)) ? onev : '0;
      OP_EQ: t.direct = (a == b) ? onev : '0;
      OP_NE: t.direct = (a != b) ? onev : '0;
      OP_AND: t.direct = a & b;
      OP_XOR: t.direct = a ^ b;
      OP_OR: t.direct = a | b;
      OP_LAND: t.direct = (a != '0 && b != '0) ? onev : '0;
      OP_LOR: t.direct = (a != '0 || b != '0) ? onev : '0;
      default: t.direct = '0;
    endcase
    if (t.fault != FAULT_NONE) begin
      t.direct = '0;
      if (in_word.suppress_faults) begin
        t.fault = FAULT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_wp_r <= ~q_wp_r;
      end
      if (q_pop) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hdl/swia_back.sv =====
module swia_back import swia_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  task_t     q_head,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  state_t state_r, state_nxt;
  task_t job_r;
  logic [OpWidth-1:0] x_r, y_r, acc_r, rem_r;
  logic [StepWidth-1:0] step_r;
  logic [OpWidth-1:0] prod;
  logic [OpWidth:0] trial;
  logic [OpWidth-1:0] rem_sh;
  logic [OpWidth-1:0] res_out;
  logic [1:0] fault_out;
  logic done_take;
  logic [1:0] ph_r;
  logic mul_run, mul_last;
  logic [OpWidth-1:0] mul_p, mul_q;
  logic [FullWidth-1:0] mul_pe, mul_qe, lo_r, m_prod, full_prod;
  logic [HalfWidth-1:0] m_a, m_b, cross_r;

  assign done_take = (state_r == ST_DONE) && !out_stall;

  always_comb begin
    mul_run = (state_r == ST_MUL) || (state_r == ST_POW_SQR) ||
              ((state_r == ST_POW_MUL) && (y_r != '0) && y_r[0]);
    mul_last = mul_run && (ph_r == 2'd2);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_head.kind)
            KIND_MUL: state_nxt = ST_MUL;
            KIND_DIV: state_nxt = ST_DIV;
            KIND_POW: state_nxt = ST_POW_MUL;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: if (mul_last) state_nxt = ST_DONE;
      ST_DIV: if (step_r == StepWidth'(1)) state_nxt = ST_FIX;
      ST_POW_MUL: begin
        if (y_r == '0) begin
          state_nxt = ST_DONE;
        end else if (!y_r[0] || mul_last) begin
          state_nxt = ST_POW_SQR;
        end
      end
      ST_POW_SQR: if (mul_last) state_nxt = ST_POW_MUL;
      ST_FIX: state_nxt = ST_DONE;
      ST_DONE: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == ST_IDLE) && q_valid;
    out_valid = (state_r == ST_DONE);
    out_word.result_value = widen(res_out);
    out_word.fault_code = fault_out;
  end

  // Each product is built from three half-width partial products, one per cycle.
  always_comb begin
    case (state_r)
      ST_POW_MUL: begin
        mul_p = acc_r;
        mul_q = x_r;
      end
      ST_POW_SQR: begin
        mul_p = x_r;
        mul_q = x_r;
      end
      default: begin
        mul_p = job_r.a;
        mul_q = job_r.b;
      end
    endcase
    mul_pe = FullWidth'(mul_p);
    mul_qe = FullWidth'(mul_q);
    m_a = (ph_r == 2'd2) ? mul_pe[FullWidth-1:HalfWidth] : mul_pe[HalfWidth-1:0];
    m_b = (ph_r == 2'd1) ? mul_qe[FullWidth-1:HalfWidth] : mul_qe[HalfWidth-1:0];
    m_prod = {{HalfWidth{1'b0}}, m_a} * {{HalfWidth{1'b0}}, m_b};
    full_prod = lo_r + {cross_r + m_prod[HalfWidth-1:0], {HalfWidth{1'b0}}};
    prod = full_prod[OpWidth-1:0];
  end

  always_comb begin
    rem_sh = {rem_r[OpWidth-2:0], x_r[OpWidth-1]};
    trial = {rem_r, x_r[OpWidth-1]} - {1'b0, job_r.b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 2'd0;
    end else if (mul_run) begin
      ph_r <= mul_last ? 2'd0 : ph_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_run) begin
      case (ph_r)
        2'd0: lo_r <= m_prod;
        2'd1: cross_r <= m_prod[HalfWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          job_r <= q_head;
          x_r <= q_head.a;
          y_r <= q_head.b;
          acc_r <= {{(OpWidth-1){1'b0}}, 1'b1};
          rem_r <= '0;
          step_r <= StepWidth'(OpWidth);
          res_out <= q_head.direct;
          fault_out <= q_head.fault;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          res_out <= prod;
        end
      end
      ST_DIV: begin
        if (!trial[OpWidth]) begin
          rem_r <= trial[OpWidth-1:0];
          x_r <= {x_r[OpWidth-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          x_r <= {x_r[OpWidth-2:0], 1'b0};
        end
        step_r <= step_r - StepWidth'(1);
      end
      ST_POW_MUL: begin
        if (y_r == '0) begin
          res_out <= acc_r;
        end else if (mul_last) begin
          acc_r <= prod;
        end
      end
      ST_POW_SQR: begin
        if (mul_last) begin
          x_r <= prod;
          y_r <= y_r >> 1;
        end
      end
      ST_FIX: begin
        res_out <= job_r.is_mod ? (job_r.neg_res ? -rem_r : rem_r)
                                : (job_r.neg_res ? -x_r : x_r);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

// ===== hdl/signed_wrapping_integer_alu_core.sv =====
// Channel | Ports                          | Word
// input   | in_valid, in_stall, in_word    | operator, operands, suppress flag
// output  | out_valid, out_stall, out_word | result value, fault code
// Simple operators are computed in the front end and held in the queue; the back end loads the result and offers it.
// Multiply uses one half-width multiplier; divide is bit-serial over the operand width, then fixes the sign.
// Power squares the base for each exponent bit up to the highest set bit and multiplies for each set bit.
// A two-word queue lets the front end accept while the back end works or stalls.
// Reset is synchronous and active low and empties the queue and the back end.
module signed_wrapping_integer_alu_core import swia_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic q_valid, q_pop;
  task_t q_head;

  swia_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  swia_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

endmodule

// ===== hdl/swia_checker.sv =====
module swia_checker import swia_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.fault_code != FAULT_NONE |-> out_word.result_value == '0)
    else $error("fault with nonzero result");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.fault_code != 2'd3)
    else $error("invalid fault code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind signed_wrapping_integer_alu_core swia_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);

// ===== test/signed_wrapping_integer_alu_core_tb.sv =====
`timescale 1ns / 1ps
module signed_wrapping_integer_alu_core_tb;
  import swia_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  out_word_t expected_words[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycle_count = 0;
  bit hold_off = 1'b0;
  bit stall_enable = 1'b0;
  int burst_left = 0;

  localparam int CycleLimit = 5000000;

  always #6 clk = ~clk;

  signed_wrapping_integer_alu_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

  function automatic logic [63:0] sign_fix(input logic [63:0] v);
    return 64'($signed(v[OpWidth-1:0]));
  endfunction

  function automatic logic [63:0] pow_wrapped(input logic [63:0] base, input logic [63:0] ex);
    logic [63:0] acc;
    acc = 64'd1;
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic out_word_t alu_result(input in_word_t w);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] minv;
    logic [63:0] r;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [1:0] fault;
    int cnt;
    out_word_t res;
    a = sign_fix(w.left_operand);
    b = sign_fix(w.right_operand);
    minv = sign_fix(64'd1 << (OpWidth - 1));
    r = '0;
    fault = FAULT_NONE;
    cnt = int'(b & 64'(OpWidth - 1));
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    case (w.req_type)
      OP_POW: begin
        if (b[63]) fault = FAULT_NEG_EXP;
        else r = pow_wrapped(a, b);
      end
      OP_MUL: r = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          fault = FAULT_DIV_ZERO;
        end else if (a == minv && b == -64'sd1) begin
          r = (w.req_type == OP_DIV) ? minv : '0;
        end else if (w.req_type == OP_DIV) begin
          r = ma / mb;
          if (a[63] != b[63]) r = -r;
        end else begin
          r = ma % mb;
          if (a[63]) r = -r;
        end
      end
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_SHL: r = a << cnt;
      OP_SAR: r = a >>> cnt;
      OP_LT: r = 64'(a < b);
      OP_LE: r = 64'(a <= b);
      OP_GT: r = 64'(a > b);
      OP_GE: r = 64'(a >= b);
      OP_EQ: r = 64'(a == b);
      OP_NE: r = 64'(a != b);
      OP_AND: r = a & b;
      OP_XOR: r = a ^ b;
      OP_OR: r = a | b;
      OP_LAND: r = 64'(a != 0 && b != 0);
      OP_LOR: r = 64'(a != 0 || b != 0);
      default: r = '0;
    endcase
    if (fault != FAULT_NONE) begin
      r = '0;
      if (w.suppress_faults) fault = FAULT_NONE;
    end
    res.result_value = sign_fix(r);
    res.fault_code = fault;
    return res;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(alu_result(w));
    words_sent++;
  endtask

  task automatic send_op(input logic [4:0] op, input logic [63:0] a, input logic [63:0] b,
                         input logic q);
    in_word_t w;
    w.req_type = op;
    w.left_operand = a;
    w.right_operand = b;
    w.suppress_faults = q;
    send_word(w);
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'($signed($urandom_range(0, 16)) - 8);
      3: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    op_t op;
    send_op(OP_DIV, 64'd7, 64'd0, 1'b0);
    send_op(OP_MOD, 64'd7, 64'd0, 1'b1);
    send_op(OP_POW, 64'd3, -64'sd2, 1'b0);
    send_op(OP_POW, 64'd3, -64'sd2, 1'b1);
    send_op(OP_DIV, 64'h8000_0000_0000_0000, -64'sd1, 1'b0);
    send_op(OP_MOD, 64'h8000_0000_0000_0000, -64'sd1, 1'b0);
    send_op(OP_SHL, 64'd1, -64'sd1, 1'b0);
    send_op(OP_SAR, 64'h8000_0000_0000_0000, 64'd65, 1'b0);
    send_op(OP_POW, 64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 1'b0);
    send_op(5'd19, 64'd5, 64'd5, 1'b0);
    send_op(5'd31, '1, '1, 1'b1);
    op = op.first();
    forever begin
      send_op(op, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 1'b0);
      if (op == op.last()) break;
      op = op.next();
    end
  endtask

  task automatic test_random(input int count);
    logic [4:0] op;
    repeat (count) begin
      op = $urandom_range(0, 15) == 0 ? 5'($urandom_range(19, 31)) : 5'($urandom_range(0, 18));
      send_op(op, pick_operand(), pick_operand(), 1'($urandom));
    end
  endtask

  task automatic test_back_pressure();
    hold_off = 1'b1;
    test_random(12);
    hold_off = 1'b0;
  endtask

  task automatic test_stalls();
    stall_enable = 1'b1;
    test_random(1700);
    stall_enable = 1'b0;
  endtask

  initial begin
    int hold_cycles;
    forever begin
      @(posedge clk);
      hold_cycles = 0;
      if (hold_off) begin
        out_stall <= 1'b1;
        while (hold_cycles < 300) begin
          @(posedge clk);
          hold_cycles++;
        end
        out_stall <= 1'b0;
        wait (!hold_off);
      end else if (stall_enable) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t exp_word;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got %h/%0d", $time, out_word.result_value,
                 out_word.fault_code);
      end else begin
        exp_word = expected_words.pop_front();
        words_checked++;
        if (out_word.result_value !== exp_word.result_value) begin
          errors++;
          $display("%0t: result mismatch, expected %h, got %h", $time,
                   exp_word.result_value, out_word.result_value);
        end
        if (out_word.fault_code !== exp_word.fault_code) begin
          errors++;
          $display("%0t: fault mismatch, expected %0d, got %0d", $time,
                   exp_word.fault_code, out_word.fault_code);
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("signed_wrapping_integer_alu_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_pressure();
    test_stalls();
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (expected_words.size() != 0) errors++;
    $display("Sent %0d words covering all operators, faults, suppression and edge operands;",
             words_sent);
    $display("checked %0d results under random gaps, stalls and one long hold-off.",
             words_checked);
    if (errors == 0) begin
      $display("signed_wrapping_integer_alu_core verification clean");
    end else begin
      $display("signed_wrapping_integer_alu_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/swia_pkg.sv
hdl/swia_front.sv
hdl/swia_back.sv
hdl/signed_wrapping_integer_alu_core.sv
hdl/swia_checker.sv
test/signed_wrapping_integer_alu_core_tb.sv
